### hw/rtl/efd_pkg.sv
`default_nettype none

package efd_pkg;

    // Framing constants
    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam int         VALUE_BYTES = 4;
    localparam int         IDX_W       = $clog2(VALUE_BYTES);
    localparam logic [IDX_W-1:0] LAST_VALUE_IDX = IDX_W'(VALUE_BYTES - 1);
    localparam int         SUM_W       = 10;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    // Receive phase: hunting for sync, value bytes, checksum high, checksum low
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_VALUE,
        PH_CHECK_HI,
        PH_CHECK_LO
    } efd_phase_t;

    // One frame result
    typedef struct packed {
        logic               frame_ok;
        logic signed [31:0] position_value;
        logic [31:0]        mismatch_count;
    } efd_result_t;

endpackage

`default_nettype wire

### hw/rtl/efd_byte_if.sv
`default_nettype none

interface efd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/efd_result_if.sv
`default_nettype none

interface efd_result_if;
    logic               valid;
    logic               ready;
    logic               frame_ok;
    logic signed [31:0] position_value;
    logic [31:0]        mismatch_count;

    modport source (output valid, output frame_ok, output position_value,
                    output mismatch_count, input ready);
    modport sink   (input valid, input frame_ok, input position_value,
                    input mismatch_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/efd_core.sv
`default_nettype none

module efd_core
    import efd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_en,
    input  wire logic [7:0]  rx_byte,
    output logic             done,
    output efd_result_t      result
);

    efd_phase_t             phase_reg, phase_next;
    logic                   sync_seen_reg, sync_seen_next;
    logic [IDX_W-1:0]       index_reg, index_next;
    logic [31:0]            value_reg, value_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [7:0]             check_high_reg, check_high_next;
    logic [31:0]            good_value_reg, good_value_next;
    logic [31:0]            error_total_reg, error_total_next;

    logic                   is_sync;
    logic                   take_value;
    logic                   take_check_hi;
    logic                   finish;
    logic                   match;

    assign is_sync = (rx_byte == SYNC_BYTE);

    // Phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        if (byte_en)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (is_sync && sync_seen_reg)
                        phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    if (index_reg == LAST_VALUE_IDX)
                        phase_next = PH_CHECK_HI;
                end
                PH_CHECK_HI: phase_next = PH_CHECK_LO;
                PH_CHECK_LO: phase_next = PH_HUNT;
                default:     phase_next = PH_HUNT;
            endcase
        end
    end

    // Per-phase strobes
    always_comb
    begin
        take_value    = 1'b0;
        take_check_hi = 1'b0;
        finish        = 1'b0;
        unique case (phase_reg)
            PH_HUNT:     ;
            PH_VALUE:    take_value    = byte_en;
            PH_CHECK_HI: take_check_hi = byte_en;
            PH_CHECK_LO: finish        = byte_en;
            default:     ;
        endcase
    end

    // Sync run: only counted while hunting, cleared at the end of a frame
    always_comb
    begin
        sync_seen_next = sync_seen_reg;
        if (byte_en && (phase_reg == PH_HUNT))
            sync_seen_next = is_sync && !sync_seen_reg;
        else if (finish)
            sync_seen_next = 1'b0;
    end

    // Value assembly and running sum; first value byte restarts the sum
    always_comb
    begin
        index_next      = index_reg;
        value_next      = value_reg;
        sum_next        = sum_reg;
        check_high_next = check_high_reg;
        if (take_value)
        begin
            index_next = index_reg + IDX_W'(1);
            value_next = {value_reg[23:0], rx_byte};
            if (index_reg == '0)
                sum_next = {{(SUM_W-8){1'b0}}, rx_byte};
            else
                sum_next = sum_reg + {{(SUM_W-8){1'b0}}, rx_byte};
        end
        if (take_check_hi)
            check_high_next = rx_byte;
    end

    // Checksum compare and frame update
    assign match = ({check_high_reg, rx_byte} == {{(16-SUM_W){1'b0}}, sum_reg});

    always_comb
    begin
        good_value_next  = good_value_reg;
        error_total_next = error_total_reg;
        if (finish)
        begin
            if (match)
                good_value_next = value_reg;
            else if (error_total_reg != COUNT_MAX)
                error_total_next = error_total_reg + 32'd1;
        end
    end

    assign done                  = finish;
    assign result.frame_ok       = match;
    assign result.position_value = good_value_next;
    assign result.mismatch_count = error_total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            sync_seen_reg   <= 1'b0;
            index_reg       <= '0;
            value_reg       <= '0;
            sum_reg         <= '0;
            check_high_reg  <= '0;
            good_value_reg  <= '0;
            error_total_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            sync_seen_reg   <= sync_seen_next;
            index_reg       <= index_next;
            value_reg       <= value_next;
            sum_reg         <= sum_next;
            check_high_reg  <= check_high_next;
            good_value_reg  <= good_value_next;
            error_total_reg <= error_total_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/encoder_frame_deframer.sv
`default_nettype none

// Channel | Dir | Payload                                      | Transfer
// rx      | in  | rx_byte[7:0]                                 | valid && ready
// res     | out | frame_ok, position_value[31:0] (signed),     | valid && ready
//         |     | mismatch_count[31:0]                         |
//
// One byte is taken per cycle; the frame result appears in the output
// register the cycle after the last checksum byte is taken.
// rx.ready drops only while a result waits in the output register and
// res.ready is low; a result taken in the same cycle frees the slot.
// Reset (rst_n low, asynchronous) returns to sync hunting, clears the good
// value and the mismatch count, and empties the output register.

module encoder_frame_deframer
    import efd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    efd_byte_if.sink      rx,
    efd_result_if.source  res
);

    logic        out_valid_reg;
    efd_result_t result_reg;
    logic        accept;
    logic        done;
    efd_result_t result;

    assign rx.ready = !out_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;

    efd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (accept),
        .rx_byte (rx.rx_byte),
        .done    (done),
        .result  (result)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (done)
            result_reg <= result;
    end

    assign res.valid          = out_valid_reg;
    assign res.frame_ok       = result_reg.frame_ok;
    assign res.position_value = result_reg.position_value;
    assign res.mismatch_count = result_reg.mismatch_count;

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import efd_pkg::*;

    localparam int PAYLOAD_LEN = 6;

    // Checksum flavours for generated frames
    typedef enum int {
        CK_GOOD,
        CK_BAD_LOW,
        CK_BAD_HIGH,
        CK_RANDOM
    } ck_kind_t;

    logic clk;
    logic rst_n;

    efd_byte_if   rx_if ();
    efd_result_if res_if ();

    encoder_frame_deframer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    // Deframer shadow state
    logic [1:0]  sync_run;
    logic        capturing;
    logic [2:0]  pay_idx;
    logic [31:0] shift_val;
    logic [9:0]  sum_val;
    logic [7:0]  chk_hi;
    logic [31:0] good_val;
    logic [31:0] err_total;

    efd_result_t frame_results_q [$];

    int err_count;
    int bytes_sent;
    int frames_seen;
    int bad_frames_seen;

    // Idle controls for both sides
    bit rx_idle_on;
    bit res_idle_on;
    bit res_long_stall;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, frame_results_q.size());
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Value bytes biased towards the extremes
    function automatic logic [31:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Shadow deframer: updates state for one accepted byte, queues any frame result
    task automatic track_rx_byte(input logic [7:0] b);
        efd_result_t r;
        logic        ok;
        if (!capturing)
        begin
            if (b == SYNC_BYTE)
                sync_run = sync_run + 2'd1;
            else
                sync_run = '0;
            if (sync_run == 2'd2)
            begin
                capturing = 1'b1;
                pay_idx   = '0;
                shift_val = '0;
                sum_val   = '0;
                chk_hi    = '0;
            end
        end
        else if (pay_idx < 3'(VALUE_BYTES))
        begin
            shift_val = {shift_val[23:0], b};
            sum_val   = sum_val + 10'(b);
            pay_idx   = pay_idx + 3'd1;
        end
        else if (pay_idx < 3'(PAYLOAD_LEN - 1))
        begin
            chk_hi  = b;
            pay_idx = pay_idx + 3'd1;
        end
        else
        begin
            // last checksum byte closes the frame; full 16 bits compared
            ok = ({chk_hi, b} == {6'b0, sum_val});
            if (ok)
                good_val = shift_val;
            else if (err_total != COUNT_MAX)
                err_total = err_total + 32'd1;
            capturing = 1'b0;
            pay_idx   = '0;
            sync_run  = '0;
            r.frame_ok       = ok;
            r.position_value = good_val;
            r.mismatch_count = err_total;
            frame_results_q = {frame_results_q, r};
        end
    endtask

    // One byte transfer on the rx channel, with an optional gap in front
    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = rx_idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            rx_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        bytes_sent++;
        track_rx_byte(b);
    endtask

    task automatic send_noise(input int n);
        repeat (n)
            send_rx(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
    endtask

    // Sync pair, four value bytes, 16-bit checksum
    task automatic send_frame(input logic [31:0] val, input ck_kind_t kind);
        logic [9:0]  s;
        logic [15:0] ck;
        s  = 10'(val[31:24]) + 10'(val[23:16]) + 10'(val[15:8]) + 10'(val[7:0]);
        ck = {6'b0, s};
        case (kind)
            CK_BAD_LOW:  ck = ck ^ (16'd1 << $urandom_range(0, 9));
            CK_BAD_HIGH: ck[15:10] = 6'($urandom_range(1, 63));
            CK_RANDOM:   ck = 16'($urandom);
            default:     ;
        endcase
        send_rx(SYNC_BYTE);
        send_rx(SYNC_BYTE);
        send_rx(val[31:24]);
        send_rx(val[23:16]);
        send_rx(val[15:8]);
        send_rx(val[7:0]);
        send_rx(ck[15:8]);
        send_rx(ck[7:0]);
    endtask

    function automatic ck_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return CK_GOOD;
        if (r < 80)
            return CK_BAD_LOW;
        if (r < 90)
            return CK_BAD_HIGH;
        return CK_RANDOM;
    endfunction

    // Sender holds off until every expected result has been taken
    task automatic wait_all_results();
        @(negedge clk);
        rx_if.valid = 1'b0;
        wait (frame_results_q.size() == 0);
    endtask

    // Result sink: random stalls on ready
    initial
    begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready = 1'b1;
                if (res_long_stall && $urandom_range(0, 1) == 0)
                    stall_left = $urandom_range(5, 60);
                else if (res_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        efd_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            frames_seen++;
            if (!res_if.frame_ok)
                bad_frames_seen++;
            if (frame_results_q.size() == 0)
            begin
                $display("%0t: unexpected result ok=%0b pos=%0d cnt=%0d", $time,
                         res_if.frame_ok, res_if.position_value, res_if.mismatch_count);
                err_count++;
            end
            else
            begin
                want = frame_results_q.pop_front();
                if (res_if.frame_ok !== want.frame_ok)
                begin
                    $display("%0t: frame_ok expected %0b got %0b", $time,
                             want.frame_ok, res_if.frame_ok);
                    err_count++;
                end
                if (res_if.position_value !== want.position_value)
                begin
                    $display("%0t: position_value expected %0d got %0d", $time,
                             want.position_value, res_if.position_value);
                    err_count++;
                end
                if (res_if.mismatch_count !== want.mismatch_count)
                begin
                    $display("%0t: mismatch_count expected %0d got %0d", $time,
                             want.mismatch_count, res_if.mismatch_count);
                    err_count++;
                end
            end
        end
    end

    // Hand-built frames: extreme values, sync bytes as data, broken sync,
    // extra sync byte falling into the payload, checksum high byte out of range
    task automatic test_directed();
        logic [7:0] seq [] = '{
            8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h81,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03, 8'hFC,
            8'h12, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFE,
            8'h13, 8'h7B};
        foreach (seq[i])
            send_rx(seq[i]);
        wait_all_results();
    endtask

    // Frames with no gaps on either side
    task automatic test_back_to_back();
        rx_idle_on  = 1'b0;
        res_idle_on = 1'b0;
        repeat (15)
            send_frame(rand_value(), pick_kind());
        wait_all_results();
        rx_idle_on  = 1'b1;
        res_idle_on = 1'b1;
    endtask

    // Mostly well-formed frames, mixed with noise, broken and cut-short frames
    task automatic test_random_traffic();
        int start;
        int r;
        int k;
        start = bytes_sent;
        while (bytes_sent < start + 360)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_frame(rand_value(), pick_kind());
            else if (r < 85)
                send_noise($urandom_range(1, 6));
            else if (r < 93)
            begin
                send_rx(SYNC_BYTE);
                send_rx(8'($urandom_range(0, 254)));
            end
            else
            begin
                // frame cut short; the next bytes land in its payload
                send_rx(SYNC_BYTE);
                send_rx(SYNC_BYTE);
                k = $urandom_range(0, 5);
                repeat (k)
                    send_rx(8'($urandom));
            end
            if ($urandom_range(0, 24) == 0)
                wait_all_results();
        end
        wait_all_results();
    endtask

    // Long result stalls so that rx backs up
    task automatic test_result_backpressure();
        rx_idle_on     = 1'b0;
        res_long_stall = 1'b1;
        repeat (12)
            send_frame(rand_value(), pick_kind());
        wait_all_results();
        rx_idle_on     = 1'b1;
        res_long_stall = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        rx_if.valid     = 1'b0;
        rx_if.rx_byte   = '0;
        rx_idle_on      = 1'b1;
        res_idle_on     = 1'b1;
        res_long_stall  = 1'b0;
        err_count       = 0;
        bytes_sent      = 0;
        frames_seen     = 0;
        bad_frames_seen = 0;
        sync_run        = '0;
        capturing       = 1'b0;
        pay_idx         = '0;
        shift_val       = '0;
        sum_val         = '0;
        chk_hi          = '0;
        good_val        = '0;
        err_total       = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_random_traffic();
        test_result_backpressure();

        repeat (10) @(posedge clk);
        $display("Sent %0d bytes; checked %0d frames, %0d of them with a bad checksum.",
                 bytes_sent, frames_seen, bad_frames_seen);
        $display("Traffic mixed noise, broken sync and cut frames with gaps and stalls.");
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/efd_pkg.sv
hw/rtl/efd_byte_if.sv
hw/rtl/efd_result_if.sv
hw/rtl/efd_core.sv
hw/rtl/encoder_frame_deframer.sv
verif/tb_top.sv
